### rtl/fmq_pkg.sv
// Shared types and constants for the fixed-size message queue.
// No dependencies; the interfaces, the top level, the control and the response stage import this package.
package fmq_pkg;

   // Fixed field widths of the request, response and register port
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int IO_WORD_W   = 32;
   localparam int IO_WORDS    = 8;
   localparam int DEPTH_REG_W = 5;
   localparam int WORDS_REG_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // Register reset values
   localparam logic [DEPTH_REG_W-1:0] DEPTH_RESET = 5'd16;
   localparam logic [WORDS_REG_W-1:0] WORDS_RESET = 4'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SEND  = 2'd0,
      OP_RECV  = 2'd1,
      OP_FLUSH = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUEUE_DEPTH   = 2'd0,
      CSR_MESSAGE_WORDS = 2'd1,
      CSR_LIFO_MODE     = 2'd2
   } csr_index_type;

   // Per-beat bookkeeping handed from the pointer control to the response stage
   typedef struct packed {
      logic                   recv;
      status_type             status;
      logic [COUNT_W-1:0]     count;
      logic [WORDS_REG_W-1:0] words;
   } beat_info_type;

endpackage

### rtl/fmq_req_if.sv
// Request channel of the message queue: valid/ready handshake and payload.
// Depends on fmq_pkg for field widths.
interface fmq_req_if;
   import fmq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [IO_WORD_W-1:0] in_word_0;
   logic [IO_WORD_W-1:0] in_word_1;
   logic [IO_WORD_W-1:0] in_word_2;
   logic [IO_WORD_W-1:0] in_word_3;
   logic [IO_WORD_W-1:0] in_word_4;
   logic [IO_WORD_W-1:0] in_word_5;
   logic [IO_WORD_W-1:0] in_word_6;
   logic [IO_WORD_W-1:0] in_word_7;

   modport source (
      output valid, opcode, in_word_0, in_word_1, in_word_2, in_word_3,
             in_word_4, in_word_5, in_word_6, in_word_7,
      input  ready
   );
   modport sink (
      input  valid, opcode, in_word_0, in_word_1, in_word_2, in_word_3,
             in_word_4, in_word_5, in_word_6, in_word_7,
      output ready
   );
endinterface

### rtl/fmq_rsp_if.sv
// Response channel of the message queue: valid/ready handshake and payload.
// Depends on fmq_pkg for field widths.
interface fmq_rsp_if;
   import fmq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [COUNT_W-1:0]   held_count;
   logic [IO_WORD_W-1:0] out_word_0;
   logic [IO_WORD_W-1:0] out_word_1;
   logic [IO_WORD_W-1:0] out_word_2;
   logic [IO_WORD_W-1:0] out_word_3;
   logic [IO_WORD_W-1:0] out_word_4;
   logic [IO_WORD_W-1:0] out_word_5;
   logic [IO_WORD_W-1:0] out_word_6;
   logic [IO_WORD_W-1:0] out_word_7;

   modport source (
      output valid, status, held_count, out_word_0, out_word_1, out_word_2,
             out_word_3, out_word_4, out_word_5, out_word_6, out_word_7,
      input  ready
   );
   modport sink (
      input  valid, status, held_count, out_word_0, out_word_1, out_word_2,
             out_word_3, out_word_4, out_word_5, out_word_6, out_word_7,
      output ready
   );
endinterface

### rtl/fifo_lifo_message_queue.sv
// Message queue top level: ring of fixed-size messages, FIFO or LIFO receive.
// Path: the read stage registers the store read and the beat bookkeeping, then the
// response register takes them over; a held response can stall the read stage.
// Throughput: one beat per cycle; a held response stalls requests once the read stage is full.
// Reset clears pointers and count and loads the registers' reset values; store contents stay undefined.
// Depends on fmq_pkg, fmq_req_if, fmq_rsp_if, fmq_ram, fmq_ctrl, fmq_rsp_stage.
module fifo_lifo_message_queue #(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_WORDS   = 8,
   parameter int WORD_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [fmq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fmq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   fmq_req_if.sink                         req_chan,
   fmq_rsp_if.source                       rsp_chan
);
   import fmq_pkg::*;

   localparam int PTR_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int MSG_BITS = MAX_WORDS * WORD_BITS;

   logic                 req_accept;
   logic                 in_ready;
   logic                 wr_en, rd_en;
   logic [PTR_W-1:0]     wr_addr, rd_addr;
   logic [MSG_BITS-1:0]  wr_data, rd_data;
   logic [IO_WORD_W-1:0] in_words [IO_WORDS];
   beat_info_type        info;

   assign req_chan.ready = in_ready;
   assign req_accept     = req_chan.valid && in_ready;

   assign in_words[0] = req_chan.in_word_0;
   assign in_words[1] = req_chan.in_word_1;
   assign in_words[2] = req_chan.in_word_2;
   assign in_words[3] = req_chan.in_word_3;
   assign in_words[4] = req_chan.in_word_4;
   assign in_words[5] = req_chan.in_word_5;
   assign in_words[6] = req_chan.in_word_6;
   assign in_words[7] = req_chan.in_word_7;

   // Pack the message; store zeros past the configured length
   for (genvar j = 0; j < MAX_WORDS; j++) begin : g_pack
      assign wr_data[j*WORD_BITS +: WORD_BITS] =
         (4'(j) < info.words) ? WORD_BITS'(in_words[j]) : '0;
   end

   fmq_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_WORDS   (MAX_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .opcode    (req_chan.opcode),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   fmq_ram #(
      .WIDTH (MSG_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fmq_rsp_stage #(
      .MAX_WORDS (MAX_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_rsp (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .info     (info),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .rsp      (rsp_chan)
   );
endmodule

### rtl/fmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, then registered read that holds while idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/fmq_ctrl.sv
// Queue control: configuration registers, head/tail pointers and message count.
// Decides each beat's store access and status. Depends on fmq_pkg.
module fmq_ctrl #(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_WORDS   = 8,
   localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fmq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fmq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                          accept,
   input  logic [fmq_pkg::OPCODE_W-1:0]  opcode,
   output logic                          wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic                          rd_en,
   output logic [PTR_W-1:0]              rd_addr,
   output fmq_pkg::beat_info_type        info
);
   import fmq_pkg::*;

   localparam int DEPTH_W = PTR_W + 1;

   logic [DEPTH_REG_W-1:0] depth_ff;
   logic [WORDS_REG_W-1:0] words_ff;
   logic                   lifo_ff;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic [DEPTH_W-1:0]     eff_depth;
   logic [DEPTH_W-1:0]     depth_less_one;
   logic [WORDS_REG_W-1:0] eff_words;
   logic [DEPTH_W-1:0]     head_inc, tail_inc;
   logic [PTR_W-1:0]       head_next, tail_next, tail_prev;
   logic                   full, empty;
   status_type             status;

   // Clamp the configured depth and message length to the supported range
   always_comb begin
      if (depth_ff == '0) begin
         eff_depth = DEPTH_W'(1);
      end else if (32'(depth_ff) > MAX_ENTRIES) begin
         eff_depth = DEPTH_W'(MAX_ENTRIES);
      end else begin
         eff_depth = DEPTH_W'(depth_ff);
      end
      if (words_ff == '0) begin
         eff_words = WORDS_REG_W'(1);
      end else if (32'(words_ff) > MAX_WORDS) begin
         eff_words = WORDS_REG_W'(MAX_WORDS);
      end else begin
         eff_words = words_ff;
      end
   end

   // Ring pointer steps, wrapping at the current depth
   assign depth_less_one = eff_depth - DEPTH_W'(1);
   assign head_inc  = {1'b0, head_ff} + DEPTH_W'(1);
   assign tail_inc  = {1'b0, tail_ff} + DEPTH_W'(1);
   assign head_next = (head_inc >= eff_depth) ? '0 : head_inc[PTR_W-1:0];
   assign tail_next = (tail_inc >= eff_depth) ? '0 : tail_inc[PTR_W-1:0];
   assign tail_prev = (tail_ff == '0) ? depth_less_one[PTR_W-1:0] : tail_ff - 1'b1;

   assign full  = 32'(count_ff) >= 32'(eff_depth);
   assign empty = (count_ff == '0);

   // Decode the beat: pointer and count updates, store access, status
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      status   = ST_OK;
      unique case (opcode)
         OP_SEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_en    = accept;
               tail_in  = tail_next;
               count_in = count_ff + 1'b1;
            end
         end
         OP_RECV: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_en    = accept;
               count_in = count_ff - 1'b1;
               if (lifo_ff) begin
                  tail_in = tail_prev;
                  rd_addr = tail_prev;
               end else begin
                  head_in = head_next;
               end
            end
         end
         OP_FLUSH: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign info.recv   = (opcode == OP_RECV) && !empty;
   assign info.status = status;
   assign info.count  = count_in;
   assign info.words  = eff_words;

   // Write configuration registers; advance pointers and count on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
         words_ff <= WORDS_RESET;
         lifo_ff  <= 1'b0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_QUEUE_DEPTH:   depth_ff <= csr_wdata[DEPTH_REG_W-1:0];
               CSR_MESSAGE_WORDS: words_ff <= csr_wdata[WORDS_REG_W-1:0];
               CSR_LIFO_MODE:     lifo_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read by the same beat");

   a_send_counts: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_SEND && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted send did not raise the count");

   a_empty_no_read: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_RECV && empty |-> !rd_en && status == ST_EMPTY)
      else $error("receive on empty queue touched the store");
`endif
endmodule

### rtl/fmq_rsp_stage.sv
// Response stage: holds beat bookkeeping while the store read completes,
// then loads the output register with masked message words. Depends on fmq_pkg.
module fmq_rsp_stage #(
   parameter int MAX_WORDS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  fmq_pkg::beat_info_type         info,
   input  logic [MAX_WORDS*WORD_BITS-1:0] rd_data,
   output logic                           in_ready,
   fmq_rsp_if.source                      rsp
);
   import fmq_pkg::*;

   logic                 s1_valid_ff;
   beat_info_type        s1_info_ff;
   logic                 out_valid_ff;
   status_type           out_status_ff;
   logic [COUNT_W-1:0]   out_count_ff;
   logic [IO_WORD_W-1:0] out_words_ff [IO_WORDS];
   logic [IO_WORD_W-1:0] out_words_in [IO_WORDS];
   logic                 advance;

   assign advance  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready = !s1_valid_ff || advance;

   // Select received words; zero past the message length or when nothing was read
   for (genvar j = 0; j < IO_WORDS; j++) begin : g_word
      if (j < MAX_WORDS) begin : g_used
         assign out_words_in[j] = (s1_info_ff.recv && (4'(j) < s1_info_ff.words))
                                  ? IO_WORD_W'(rd_data[j*WORD_BITS +: WORD_BITS])
                                  : '0;
      end else begin : g_unused
         assign out_words_in[j] = '0;
      end
   end

   // Advance beats from the read stage into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_info_ff <= info;
      end
      if (advance) begin
         out_status_ff <= s1_info_ff.status;
         out_count_ff  <= s1_info_ff.count;
         out_words_ff  <= out_words_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.held_count = out_count_ff;
   assign rsp.out_word_0 = out_words_ff[0];
   assign rsp.out_word_1 = out_words_ff[1];
   assign rsp.out_word_2 = out_words_ff[2];
   assign rsp.out_word_3 = out_words_ff[3];
   assign rsp.out_word_4 = out_words_ff[4];
   assign rsp.out_word_5 = out_words_ff[5];
   assign rsp.out_word_6 = out_words_ff[6];
   assign rsp.out_word_7 = out_words_ff[7];

`ifndef SYNTHESIS
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s1_info_ff.status != ST_OK |=> out_words_ff[0] == '0)
      else $error("refused beat carried message data");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |-> !in_ready)
      else $error("new beat taken while read stage is stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(out_count_ff))
      else $error("stalled response dropped or changed");
`endif
endmodule
